@@ rtl/rgb_triangle_pulse_generator_top_macros.svh @@
// Assertion macros shared by the pulse generator RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef RGB_TRIANGLE_PULSE_GENERATOR_TOP_MACROS_SVH
`define RGB_TRIANGLE_PULSE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RTPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTPG_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RTPG_ASSERT(label, prop, msg)
`define RTPG_ASSERT_NEVER(label, expr, msg)
`endif
`endif

@@ rtl/rtpg_pkg.sv @@
// Shared constants, types and codes for the RGB triangle pulse generator.
// No dependencies; used by rtpg_ctrl, rtpg_datapath and the top level.
package rtpg_pkg;

    localparam int INTERVAL_BITS = 24;
    localparam int STEP_BITS     = 16;

    localparam int PEAK_BITS     = 8;
    localparam int IVL_REG_BITS  = 24;
    localparam int TOTAL_BITS    = 16;
    localparam int LEVEL_BITS    = 8;
    localparam int NUM_COLORS    = 3;

    localparam int CFG_DATA_BITS = (IVL_REG_BITS > TOTAL_BITS) ?
                                   ((IVL_REG_BITS > PEAK_BITS) ? IVL_REG_BITS : PEAK_BITS) :
                                   ((TOTAL_BITS > PEAK_BITS) ? TOTAL_BITS : PEAK_BITS);
    localparam int CFG_IDX_BITS  = 3;

    // Compare widths wide enough for both operands.
    localparam int CNT_CMP_BITS  = (INTERVAL_BITS > IVL_REG_BITS) ? INTERVAL_BITS : IVL_REG_BITS;
    localparam int POS_CMP_BITS  = (STEP_BITS > TOTAL_BITS) ? STEP_BITS : TOTAL_BITS;
    localparam int PROD_BITS     = STEP_BITS + PEAK_BITS;
    localparam int DIV_BITS      = (PROD_BITS > TOTAL_BITS + LEVEL_BITS) ?
                                   PROD_BITS : TOTAL_BITS + LEVEL_BITS;
    localparam int DIV_STEPS     = LEVEL_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam int COLOR_RED     = 0;
    localparam int COLOR_GREEN   = 1;
    localparam int COLOR_BLUE    = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RED_PEAK      = 3'd0,
        CFG_GREEN_PEAK    = 3'd1,
        CFG_BLUE_PEAK     = 3'd2,
        CFG_TICK_INTERVAL = 3'd3,
        CFG_STEP_TOTAL    = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DELIVER
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic fire;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic fire;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/rtpg_ctrl.sv @@
// Controller state machine for the RGB triangle pulse generator.
// Depends on rtpg_pkg and the assertion macro header.
`include "rgb_triangle_pulse_generator_top_macros.svh"

module rtpg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick_valid,
    output logic                 tick_stall,
    input  rtpg_pkg::dp_status_t status,
    output rtpg_pkg::dp_cmd_t    cmd
);

    rtpg_pkg::ctrl_state_t state_reg;
    rtpg_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtpg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        tick_stall   = 1'b1;
        unique case (state_reg)
            rtpg_pkg::ST_IDLE:
            begin
                tick_stall = 1'b0;
                cmd.take   = tick_valid;
                // A tick that does not fire needs no further work.
                if (tick_valid && status.fire)
                begin
                    cmd.fire   = 1'b1;
                    state_next = rtpg_pkg::ST_DIVIDE;
                end
            end
            rtpg_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = rtpg_pkg::ST_DELIVER;
                end
            end
            rtpg_pkg::ST_DELIVER:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rtpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtpg_pkg::ST_IDLE;
            end
        endcase
    end

    `RTPG_ASSERT(a_fire_starts_divide, cmd.fire |=> state_reg == rtpg_pkg::ST_DIVIDE,
                 "firing tick did not start the divider")
    `RTPG_ASSERT(a_divide_ends, (state_reg == rtpg_pkg::ST_DIVIDE) && status.div_last |=>
                 state_reg == rtpg_pkg::ST_DELIVER, "divider did not hand over the result")
    `RTPG_ASSERT_NEVER(a_load_when_full, cmd.load_out && !status.out_free,
                       "result loaded over an item not yet taken")

endmodule

@@ rtl/rtpg_datapath.sv @@
// Datapath: configuration registers, prescaler, triangle step counter,
// three shift-subtract dividers and the output register. Depends on rtpg_pkg.
`include "rgb_triangle_pulse_generator_top_macros.svh"

module rtpg_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rtpg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rtpg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 tick,
    input  logic                                 level_stall,
    output logic                                 level_valid,
    output logic [rtpg_pkg::LEVEL_BITS-1:0]      red_level,
    output logic [rtpg_pkg::LEVEL_BITS-1:0]      green_level,
    output logic [rtpg_pkg::LEVEL_BITS-1:0]      blue_level,
    input  rtpg_pkg::dp_cmd_t                    cmd,
    output rtpg_pkg::dp_status_t                 status
);

    logic [rtpg_pkg::PEAK_BITS-1:0]     peak_reg [rtpg_pkg::NUM_COLORS];
    logic [rtpg_pkg::IVL_REG_BITS-1:0]  interval_reg;
    logic [rtpg_pkg::TOTAL_BITS-1:0]    total_reg;

    logic [rtpg_pkg::INTERVAL_BITS-1:0] tick_count_reg;
    logic [rtpg_pkg::INTERVAL_BITS-1:0] count_inc;
    logic [rtpg_pkg::STEP_BITS-1:0]     pos_reg;
    logic [rtpg_pkg::STEP_BITS-1:0]     pos_next;
    logic                               rising_reg;
    logic                               rising_next;

    logic [rtpg_pkg::DIV_CNT_BITS-1:0]  step_reg;
    logic [rtpg_pkg::DIV_BITS-1:0]      dsh_reg;
    logic [rtpg_pkg::DIV_BITS-1:0]      rem_reg  [rtpg_pkg::NUM_COLORS];
    logic [rtpg_pkg::LEVEL_BITS-1:0]    quo_reg  [rtpg_pkg::NUM_COLORS];
    logic                               sat_reg  [rtpg_pkg::NUM_COLORS];
    logic [rtpg_pkg::DIV_BITS-1:0]      sat_limit;

    logic                               out_valid_reg;
    logic [rtpg_pkg::LEVEL_BITS-1:0]    level_reg [rtpg_pkg::NUM_COLORS];

    // Prescaler: pre-incremented count against the interval.
    assign count_inc = tick_count_reg + rtpg_pkg::INTERVAL_BITS'(1);
    assign status.fire = tick &&
        (rtpg_pkg::CNT_CMP_BITS'(count_inc) >= rtpg_pkg::CNT_CMP_BITS'(interval_reg));
    assign status.div_last = (step_reg == '0);
    assign status.out_free = !out_valid_reg || !level_stall;

    // Direction turns down at or above the step total and up at zero.
    always_comb
    begin
        rising_next = rising_reg;
        if (rtpg_pkg::POS_CMP_BITS'(pos_reg) >= rtpg_pkg::POS_CMP_BITS'(total_reg))
        begin
            rising_next = 1'b0;
        end
        else if (pos_reg == '0)
        begin
            rising_next = 1'b1;
        end
        pos_next = rising_next ? pos_reg + rtpg_pkg::STEP_BITS'(1)
                               : pos_reg - rtpg_pkg::STEP_BITS'(1);
    end

    // A quotient of 256 or more shows as a product at or above total * 256.
    assign sat_limit = rtpg_pkg::DIV_BITS'({total_reg, rtpg_pkg::LEVEL_BITS'(0)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg[rtpg_pkg::COLOR_RED]   <= '1;
            peak_reg[rtpg_pkg::COLOR_GREEN] <= '1;
            peak_reg[rtpg_pkg::COLOR_BLUE]  <= '1;
            interval_reg   <= rtpg_pkg::IVL_REG_BITS'(1);
            total_reg      <= rtpg_pkg::TOTAL_BITS'(100);
            tick_count_reg <= '0;
            pos_reg        <= '0;
            rising_reg     <= 1'b1;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rtpg_pkg::CFG_RED_PEAK:
                        peak_reg[rtpg_pkg::COLOR_RED] <= cfg_data[rtpg_pkg::PEAK_BITS-1:0];
                    rtpg_pkg::CFG_GREEN_PEAK:
                        peak_reg[rtpg_pkg::COLOR_GREEN] <= cfg_data[rtpg_pkg::PEAK_BITS-1:0];
                    rtpg_pkg::CFG_BLUE_PEAK:
                        peak_reg[rtpg_pkg::COLOR_BLUE] <= cfg_data[rtpg_pkg::PEAK_BITS-1:0];
                    rtpg_pkg::CFG_TICK_INTERVAL:
                        interval_reg <= cfg_data[rtpg_pkg::IVL_REG_BITS-1:0];
                    rtpg_pkg::CFG_STEP_TOTAL:
                        total_reg <= cfg_data[rtpg_pkg::TOTAL_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.take && tick)
            begin
                tick_count_reg <= status.fire ? '0 : count_inc;
            end
            if (cmd.fire)
            begin
                rising_reg <= rising_next;
                pos_reg    <= pos_next;
                step_reg   <= rtpg_pkg::DIV_CNT_BITS'(rtpg_pkg::DIV_STEPS - 1);
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg - rtpg_pkg::DIV_CNT_BITS'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!level_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Dividers: products are captured from the position before it moves,
    // then one quotient bit per lane is resolved each cycle, MSB first.
    always_ff @(posedge clk)
    begin
        if (cmd.fire)
        begin
            dsh_reg <= rtpg_pkg::DIV_BITS'({total_reg, (rtpg_pkg::LEVEL_BITS-1)'(0)});
            for (int c = 0; c < rtpg_pkg::NUM_COLORS; c++)
            begin
                rem_reg[c] <= rtpg_pkg::DIV_BITS'(rtpg_pkg::PROD_BITS'(pos_reg) *
                                                  rtpg_pkg::PROD_BITS'(peak_reg[c]));
            end
        end
        else if (cmd.div_step)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int c = 0; c < rtpg_pkg::NUM_COLORS; c++)
            begin
                if (step_reg == rtpg_pkg::DIV_CNT_BITS'(rtpg_pkg::DIV_STEPS - 1))
                begin
                    sat_reg[c] <= (rem_reg[c] >= sat_limit);
                end
                if (rem_reg[c] >= dsh_reg)
                begin
                    rem_reg[c] <= rem_reg[c] - dsh_reg;
                    quo_reg[c] <= {quo_reg[c][rtpg_pkg::LEVEL_BITS-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[c] <= {quo_reg[c][rtpg_pkg::LEVEL_BITS-2:0], 1'b0};
                end
            end
        end
        if (cmd.load_out)
        begin
            for (int c = 0; c < rtpg_pkg::NUM_COLORS; c++)
            begin
                if (total_reg == '0)
                begin
                    level_reg[c] <= '0;
                end
                else if (sat_reg[c])
                begin
                    level_reg[c] <= '1;
                end
                else
                begin
                    level_reg[c] <= quo_reg[c];
                end
            end
        end
    end

    assign level_valid = out_valid_reg;
    assign red_level   = level_reg[rtpg_pkg::COLOR_RED];
    assign green_level = level_reg[rtpg_pkg::COLOR_GREEN];
    assign blue_level  = level_reg[rtpg_pkg::COLOR_BLUE];

    `RTPG_ASSERT(a_pos_only_on_fire, !cmd.fire |=> $stable(pos_reg),
                 "step position moved without a firing")
    `RTPG_ASSERT(a_count_clears_on_fire, cmd.fire |=> tick_count_reg == '0,
                 "prescaler not cleared on firing")
    `RTPG_ASSERT(a_pos_moves_one, cmd.fire |=>
                 (pos_reg == $past(pos_reg) + rtpg_pkg::STEP_BITS'(1)) ||
                 (pos_reg == $past(pos_reg) - rtpg_pkg::STEP_BITS'(1)),
                 "step position did not move by one")

endmodule

@@ rtl/rgb_triangle_pulse_generator_top.sv @@
// RGB triangle pulse generator: a breathing-LED brightness source.
//
// Tick channel: tick_valid/tick_stall with the one-bit tick field. Each item
// with tick set advances a prescaler; when the count reaches tick_interval it
// clears and the block fires. Items with tick clear are taken and ignored.
// On a firing the step position walks a triangle 0..step_total..0 and one
// item leaves on the level channel (level_valid/level_stall) with each color
// equal to floor(position * peak / step_total), limited to 255 (0 if step_total is 0).
// A tick that does not fire is taken without a stall. A firing tick forms its
// products at the edge that takes it and then keeps tick_stall high while the
// per-color shift-subtract dividers resolve one quotient bit per cycle and
// until the output register is free to load. level_valid rises in the cycle
// after that load.
// The output register holds its item while level_stall is high; the next
// tick may already be taken, and a new firing waits only if the register
// is still full when its quotients are ready.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..4); the user
// must do so only while the block is idle, which the block itself does not enforce.
// Reset restores all register defaults and clears prescaler, position and output valid.
// Depends on rtpg_pkg, rtpg_ctrl and rtpg_datapath.

module rgb_triangle_pulse_generator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rtpg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rtpg_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               tick_valid,
    output logic                               tick_stall,
    input  logic                               tick,
    output logic                               level_valid,
    input  logic                               level_stall,
    output logic [rtpg_pkg::LEVEL_BITS-1:0]    red_level,
    output logic [rtpg_pkg::LEVEL_BITS-1:0]    green_level,
    output logic [rtpg_pkg::LEVEL_BITS-1:0]    blue_level
);

    rtpg_pkg::dp_cmd_t    cmd;
    rtpg_pkg::dp_status_t status;

    rtpg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .status     (status),
        .cmd        (cmd)
    );

    rtpg_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick        (tick),
        .level_stall (level_stall),
        .level_valid (level_valid),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

@@ bench/rgb_triangle_pulse_generator_top_tb.sv @@
// Self-checking testbench for rgb_triangle_pulse_generator_top: random tick traffic
// and register settings, with every level item compared against a software predictor.
// Depends on rtpg_pkg and the RTL of the pulse generator.
`timescale 1ns / 100ps

module rgb_triangle_pulse_generator_top_tb;

    import rtpg_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TICKS = 15;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int RANDOM_PHASES   = 8;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] red;
        logic [LEVEL_BITS-1:0] green;
        logic [LEVEL_BITS-1:0] blue;
    } level_set_t;

    // Tracks the prescaler and the triangle walk, and keeps the levels still owed.
    class triangle_level_model;
        logic [PEAK_BITS-1:0]     red_peak;
        logic [PEAK_BITS-1:0]     green_peak;
        logic [PEAK_BITS-1:0]     blue_peak;
        logic [IVL_REG_BITS-1:0]  interval;
        logic [TOTAL_BITS-1:0]    total;
        logic [INTERVAL_BITS-1:0] count;
        logic [STEP_BITS-1:0]     position;
        bit                       rising;
        level_set_t               levels_due[$];
        int                       errors;

        function new();
            red_peak   = 8'd255;
            green_peak = 8'd255;
            blue_peak  = 8'd255;
            interval   = 24'd1;
            total      = 16'd100;
            count      = '0;
            position   = '0;
            rising     = 1'b1;
            errors     = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_RED_PEAK:      red_peak   = value[PEAK_BITS-1:0];
                CFG_GREEN_PEAK:    green_peak = value[PEAK_BITS-1:0];
                CFG_BLUE_PEAK:     blue_peak  = value[PEAK_BITS-1:0];
                CFG_TICK_INTERVAL: interval   = value[IVL_REG_BITS-1:0];
                CFG_STEP_TOTAL:    total      = value[TOTAL_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Level is 0 for a step total of zero and saturates at 255 when the quotient exceeds 255.
        function logic [LEVEL_BITS-1:0] scale(logic [PEAK_BITS-1:0] peak);
            longint unsigned q;
            if (total == 0)
                return '0;
            q = (longint'(position) * longint'(peak)) / longint'(total);
            return (q > 255) ? 8'd255 : q[LEVEL_BITS-1:0];
        endfunction

        function void take_tick(logic t);
            level_set_t lv;
            if (!t)
                return;
            count = count + 1'b1;
            if (count < interval)
                return;
            count = '0;
            if (position >= total)
                rising = 1'b0;
            else if (position == 0)
                rising = 1'b1;
            lv.red   = scale(red_peak);
            lv.green = scale(green_peak);
            lv.blue  = scale(blue_peak);
            levels_due.push_back(lv);
            if (rising)
                position = position + 1'b1;
            else
                position = position - 1'b1;
        endfunction

        function void check_level(logic [LEVEL_BITS-1:0] r, logic [LEVEL_BITS-1:0] g,
                                  logic [LEVEL_BITS-1:0] b);
            level_set_t want;
            if (levels_due.size() == 0)
            begin
                $display("%0t: unexpected level item r=%0d g=%0d b=%0d", $time, r, g, b);
                errors++;
                return;
            end
            want = levels_due.pop_front();
            if (r !== want.red)
            begin
                $display("%0t: red_level expected %0d actual %0d", $time, want.red, r);
                errors++;
            end
            if (g !== want.green)
            begin
                $display("%0t: green_level expected %0d actual %0d", $time, want.green, g);
                errors++;
            end
            if (b !== want.blue)
            begin
                $display("%0t: blue_level expected %0d actual %0d", $time, want.blue, b);
                errors++;
            end
        endfunction

        function int unsigned waiting();
            return levels_due.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     tick_valid;
    logic                     tick_stall;
    logic                     tick;
    logic                     level_valid;
    logic                     level_stall;
    logic [LEVEL_BITS-1:0]    red_level;
    logic [LEVEL_BITS-1:0]    green_level;
    logic [LEVEL_BITS-1:0]    blue_level;

    triangle_level_model levels = new();
    bit calm;
    bit hold_request;

    rgb_triangle_pulse_generator_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .tick        (tick),
        .level_valid (level_valid),
        .level_stall (level_stall),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && level_valid && !level_stall)
            levels.check_level(red_level, green_level, blue_level);
    end

    // Receiver: random stall bursts, quiet stretches, and one long hold on request.
    initial
    begin : receiver
        int stall_left;
        int free_left;
        int hold_left;
        stall_left = 0;
        free_left  = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                level_stall <= 1'b1;
            end
            else if (calm)
                level_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                level_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                level_stall <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        stall_left = $urandom_range(1, 19) - 1;
                        level_stall <= 1'b1;
                    end
                    2:
                    begin
                        free_left = $urandom_range(20, 80);
                        level_stall <= 1'b0;
                    end
                    default: level_stall <= 1'b0;
                endcase
            end
        end
    end

    task automatic write_cfg(cfg_index_t idx, int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        levels.set_reg(idx, value[CFG_DATA_BITS-1:0]);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offers one item and returns at the edge where it is taken.
    task automatic send_tick(logic t);
        tick_valid <= 1'b1;
        tick       <= t;
        do
            @(posedge clk);
        while (tick_stall);
        levels.take_tick(t);
    endtask

    task automatic pause_sender(int cycles);
        tick_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops offering ticks and waits until every level item has arrived, then idles.
    task automatic settle();
        tick_valid <= 1'b0;
        do
            @(posedge clk);
        while (levels.waiting() > 0);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    function automatic int unsigned pick_peak();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic pick_settings();
        int unsigned ivl;
        int unsigned steps;
        case ($urandom_range(0, 5))
            0: ivl = 0;
            1: ivl = 1;
            2, 3: ivl = $urandom_range(2, 4);
            default: ivl = $urandom_range(5, 12);
        endcase
        case ($urandom_range(0, 7))
            0: steps = 1;
            1, 2: steps = $urandom_range(2, 8);
            3, 4, 5: steps = $urandom_range(9, 60);
            6: steps = $urandom_range(1, 65535);
            default: steps = 65535;
        endcase
        write_cfg(CFG_RED_PEAK, pick_peak());
        write_cfg(CFG_GREEN_PEAK, pick_peak());
        write_cfg(CFG_BLUE_PEAK, pick_peak());
        write_cfg(CFG_TICK_INTERVAL, ivl);
        write_cfg(CFG_STEP_TOTAL, steps);
    endtask

    task automatic random_ticks(int n_ticks, bit drain_midway);
        int sent;
        sent = 0;
        while (sent < n_ticks)
        begin
            // Ticks of zero are taken and ignored; they do not count.
            if ($urandom_range(0, 7) == 0)
                send_tick(1'b0);
            else
            begin
                send_tick(1'b1);
                sent++;
            end
            if (drain_midway && sent == n_ticks / 2)
            begin
                drain_midway = 1'b0;
                tick_valid <= 1'b0;
                do
                    @(posedge clk);
                while (levels.waiting() > 0);
            end
            if (!calm && $urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 19));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        tick_valid   = 1'b0;
        tick         = 1'b0;
        level_stall  = 1'b0;
        calm         = 1'b0;
        hold_request = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: every tick that is set fires and the walk climbs.
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        settle();

        // Step total of one with the position above it: nonzero peaks saturate while it falls toward the total.
        write_cfg(CFG_RED_PEAK, 0);
        write_cfg(CFG_GREEN_PEAK, 128);
        write_cfg(CFG_BLUE_PEAK, 255);
        write_cfg(CFG_TICK_INTERVAL, 0);
        write_cfg(CFG_STEP_TOTAL, 1);
        repeat (5) send_tick(1'b1);
        settle();

        write_cfg(CFG_TICK_INTERVAL, 3);
        repeat (6) send_tick(1'b1);
        settle();

        // Largest interval: the prescaler counts without firing.
        write_cfg(CFG_TICK_INTERVAL, 24'hFF_FFFF);
        repeat (2) send_tick(1'b1);
        settle();

        write_cfg(CFG_TICK_INTERVAL, 1);
        write_cfg(CFG_STEP_TOTAL, 65535);
        write_cfg(CFG_RED_PEAK, 255);
        repeat (4) send_tick(1'b1);
        settle();

        // Long hold on the level side while ticks keep coming, so the input backs up.
        write_cfg(CFG_TICK_INTERVAL, 0);
        write_cfg(CFG_STEP_TOTAL, 7);
        hold_request = 1'b1;
        repeat (40) send_tick(1'b1);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_settings();
            if (phase == RANDOM_PHASES - 1)
                calm = 1'b1;
            random_ticks(ITEMS_PER_PHASE, phase == 3);
            settle();
        end

        if (levels.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/rtpg_pkg.sv
rtl/rtpg_ctrl.sv
rtl/rtpg_datapath.sv
rtl/rgb_triangle_pulse_generator_top.sv
bench/rgb_triangle_pulse_generator_top_tb.sv
